@@ src/rc4ks_pkg.sv @@
// shared types and constants for the rc4 keystream cipher
package rc4ks_pkg;

	localparam int BYTE_W     = 8;
	localparam int PERM_DEPTH = 256;
	localparam int PERM_AW    = 8;

	typedef logic [BYTE_W-1:0] byte_t;

	typedef enum logic [1:0] {
		CMD_KEY,
		CMD_KEY_LAST,
		CMD_DATA
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		byte_t     value;
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DATA_RD_J,
		ST_DATA_SWAP,
		ST_DATA_OUT,
		ST_KS_RD_K,
		ST_KS_RD_J,
		ST_KS_WR_K,
		ST_KS_WR_J
	} core_state_t;

endpackage

@@ src/rc4ks_front.sv @@
// input side: classifies incoming items and queues them as commands
module rc4ks_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic             operation,
	input  rc4ks_pkg::byte_t byte_value,
	input  logic             last_key_byte,
	output logic             cmd_valid,
	output rc4ks_pkg::cmd_t  cmd,
	input  logic             cmd_pop
);
	import rc4ks_pkg::*;

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	cmd_t       cmd_in;
	logic       do_push;
	logic       do_pop;

	always_comb begin
		if (operation) begin
			cmd_in.kind = CMD_DATA;
		end else if (last_key_byte) begin
			cmd_in.kind = CMD_KEY_LAST;
		end else begin
			cmd_in.kind = CMD_KEY;
		end
		cmd_in.value = byte_value;
	end

	assign full      = (count_q == 2'd2);
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = entry_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_pop && cmd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= cmd_in;
		end
	end

endmodule

@@ src/rc4ks_outq.sv @@
// result side: two-entry queue of cipher bytes
module rc4ks_outq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             res_push,
	input  rc4ks_pkg::byte_t res_byte,
	output logic             res_full,
	output logic             empty,
	input  logic             pop,
	output rc4ks_pkg::byte_t cipher_byte
);
	import rc4ks_pkg::*;

	byte_t      entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign res_full    = (count_q == 2'd2);
	assign empty       = (count_q == 2'd0);
	assign cipher_byte = entry_q[rd_ptr_q];
	assign do_push     = res_push && !res_full;
	assign do_pop      = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= res_byte;
		end
	end

endmodule

@@ src/rc4ks_core.sv @@
// execution engine: key store, permutation ram, key schedule and keystream generator
module rc4ks_core #(
	parameter int KEY_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  rc4ks_pkg::cmd_t  cmd,
	output logic             cmd_pop,
	input  logic             res_full,
	output logic             res_push,
	output rc4ks_pkg::byte_t res_byte
);
	import rc4ks_pkg::*;

	localparam int KW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
	localparam int CW = $clog2(KEY_DEPTH + 1);

	// permutation ram with per-entry valid bits; an invalid entry reads as its own address
	byte_t                 perm_mem [PERM_DEPTH];
	logic [PERM_DEPTH-1:0] vld_q;
	byte_t                 rd_q;
	logic [PERM_AW-1:0]    rda_q;
	logic                  rdv_q;

	byte_t                 key_mem [KEY_DEPTH];
	byte_t                 kd_q;

	core_state_t           state_q;
	core_state_t           state_d;

	logic [PERM_AW-1:0]    idx_i_q;
	logic [PERM_AW-1:0]    idx_j_q;
	logic [CW-1:0]         key_cnt_q;
	logic [CW-1:0]         key_len_q;
	logic [KW-1:0]         kidx_q;
	logic [PERM_AW-1:0]    k_q;
	logic [PERM_AW-1:0]    ks_j_q;
	byte_t                 data_q;
	byte_t                 si_q;
	byte_t                 sj_q;
	logic [PERM_AW-1:0]    t_q;

	byte_t                 rval;
	logic [PERM_AW-1:0]    jn_data;
	logic [PERM_AW-1:0]    jn_ks;
	logic [PERM_AW-1:0]    t_sum;
	byte_t                 ks_byte;
	logic [PERM_AW-1:0]    rd_addr;
	logic                  wr_en;
	logic [PERM_AW-1:0]    wr_addr;
	byte_t                 wr_data;
	logic                  is_key;
	logic                  key_room;
	logic                  key_wr;
	logic                  key_last;
	logic [CW-1:0]         key_cnt_inc;
	logic                  kidx_wrap;

	assign rval    = rdv_q ? rd_q : rda_q;
	assign jn_data = idx_j_q + rval;
	assign jn_ks   = ks_j_q + rval + kd_q;
	assign t_sum   = si_q + rval;

	// the final lookup forwards the two swapped entries, whose writes are still in flight
	assign ks_byte = (t_q == idx_i_q) ? sj_q :
	                 (t_q == idx_j_q) ? si_q : rval;
	assign res_byte = data_q ^ ks_byte;

	assign is_key      = (cmd.kind != CMD_DATA);
	assign key_room    = (key_cnt_q < CW'(KEY_DEPTH));
	assign key_cnt_inc = key_room ? (key_cnt_q + CW'(1)) : key_cnt_q;
	assign kidx_wrap   = ((CW'(kidx_q) + CW'(1)) == key_len_q);

	always_comb begin
		state_d  = state_q;
		cmd_pop  = 1'b0;
		res_push = 1'b0;
		rd_addr  = '0;
		wr_en    = 1'b0;
		wr_addr  = idx_i_q;
		wr_data  = sj_q;
		key_wr   = 1'b0;
		key_last = 1'b0;
		case (state_q)
			ST_IDLE: begin
				rd_addr = idx_i_q + PERM_AW'(1);
				if (cmd_valid && is_key) begin
					cmd_pop = 1'b1;
					key_wr  = key_room;
					if (cmd.kind == CMD_KEY_LAST) begin
						key_last = 1'b1;
						state_d  = ST_KS_RD_K;
					end
				end else if (cmd_valid && !res_full) begin
					cmd_pop = 1'b1;
					state_d = ST_DATA_RD_J;
				end
			end
			ST_DATA_RD_J: begin
				rd_addr = jn_data;
				state_d = ST_DATA_SWAP;
			end
			ST_DATA_SWAP: begin
				rd_addr = t_sum;
				wr_en   = 1'b1;
				wr_addr = idx_j_q;
				wr_data = si_q;
				state_d = ST_DATA_OUT;
			end
			ST_DATA_OUT: begin
				wr_en    = 1'b1;
				wr_addr  = idx_i_q;
				wr_data  = sj_q;
				res_push = 1'b1;
				state_d  = ST_IDLE;
			end
			ST_KS_RD_K: begin
				rd_addr = k_q;
				state_d = ST_KS_RD_J;
			end
			ST_KS_RD_J: begin
				rd_addr = jn_ks;
				state_d = ST_KS_WR_K;
			end
			ST_KS_WR_K: begin
				wr_en   = 1'b1;
				wr_addr = k_q;
				wr_data = rval;
				state_d = ST_KS_WR_J;
			end
			ST_KS_WR_J: begin
				wr_en   = 1'b1;
				wr_addr = ks_j_q;
				wr_data = si_q;
				state_d = (k_q == PERM_AW'(PERM_DEPTH - 1)) ? ST_IDLE : ST_KS_RD_K;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			idx_i_q   <= '0;
			idx_j_q   <= '0;
			key_cnt_q <= '0;
		end else begin
			if (key_last) begin
				vld_q <= '0;
			end else if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (cmd_pop && is_key) begin
				key_cnt_q <= key_last ? '0 : key_cnt_inc;
			end
			if (key_last) begin
				idx_i_q <= '0;
				idx_j_q <= '0;
			end else if (state_q == ST_IDLE && cmd_pop && !is_key) begin
				idx_i_q <= idx_i_q + PERM_AW'(1);
			end else if (state_q == ST_DATA_RD_J) begin
				idx_j_q <= jn_data;
			end
		end
	end

	// permutation ram, one read and one write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			perm_mem[wr_addr] <= wr_data;
		end
		rd_q  <= perm_mem[rd_addr];
		rda_q <= rd_addr;
		rdv_q <= vld_q[rd_addr];
	end

	// key store
	always_ff @(posedge clk) begin
		if (key_wr) begin
			key_mem[key_cnt_q[KW-1:0]] <= cmd.value;
		end
		kd_q <= key_mem[kidx_q];
	end

	always_ff @(posedge clk) begin
		if (key_last) begin
			key_len_q <= key_cnt_inc;
			kidx_q    <= '0;
			k_q       <= '0;
			ks_j_q    <= '0;
		end
		case (state_q)
			ST_IDLE: begin
				data_q <= cmd.value;
			end
			ST_DATA_RD_J: begin
				si_q <= rval;
			end
			ST_DATA_SWAP: begin
				sj_q <= rval;
				t_q  <= t_sum;
			end
			ST_KS_RD_J: begin
				si_q   <= rval;
				ks_j_q <= jn_ks;
			end
			ST_KS_WR_J: begin
				k_q    <= k_q + PERM_AW'(1);
				kidx_q <= kidx_wrap ? '0 : (kidx_q + KW'(1));
			end
			default: begin
			end
		endcase
	end

endmodule

@@ src/rc4_keystream_cipher.sv @@
// RC4 cipher engine. Items enter through a two-entry command queue and results leave
// through a two-entry result queue; while the result queue is full, data bytes wait in
// the command queue. A key byte (operation 0) is stored if the key store has room; the
// byte marked last_key_byte then restarts the permutation from identity and runs the key
// schedule, 256 steps that each read S[k] and S[j] and write both back. A data byte
// (operation 1) passes through a dependent read, read, swap write-back and final
// lookup on the permutation RAM, which has one read and one write port, and returns
// byte_value XOR keystream. Items queued behind a key schedule wait until it finishes.
module rc4_keystream_cipher #(
	parameter int KEY_DEPTH = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic             operation,
	input  rc4ks_pkg::byte_t byte_value,
	input  logic             last_key_byte,
	output logic             empty,
	input  logic             pop,
	output rc4ks_pkg::byte_t cipher_byte
);
	import rc4ks_pkg::*;

	logic  cmd_valid;
	cmd_t  cmd;
	logic  cmd_pop;
	logic  res_full;
	logic  res_push;
	byte_t res_byte;

	rc4ks_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.operation     (operation),
		.byte_value    (byte_value),
		.last_key_byte (last_key_byte),
		.cmd_valid     (cmd_valid),
		.cmd           (cmd),
		.cmd_pop       (cmd_pop)
	);

	rc4ks_core #(
		.KEY_DEPTH (KEY_DEPTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_byte  (res_byte)
	);

	rc4ks_outq u_outq (
		.clk         (clk),
		.arst_n      (arst_n),
		.res_push    (res_push),
		.res_byte    (res_byte),
		.res_full    (res_full),
		.empty       (empty),
		.pop         (pop),
		.cipher_byte (cipher_byte)
	);

endmodule
